// ===== src/olst_pkg.sv =====
// ----------------------------------------------------------------------------
// olst_pkg
// Shared constants, codes and cell control type for the ordered list store.
// ----------------------------------------------------------------------------
package olst_pkg;

  localparam int DEPTH      = 16;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int DATA_W     = 32;
  localparam int POS_W      = 5;
  localparam int LEN_W      = 5;
  localparam int OP_W       = 3;
  localparam int ST_W       = 3;
  localparam int IN_DATA_W  = ((DATA_W + POS_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ST_W + POS_W + DATA_W + LEN_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_SEARCH    = 3'd6,
    OP_READ_ALL  = 3'd7
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_BADPOS = 3'd3,
    ST_NOKEY  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_INS  = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_ROT  = 2'd3
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e          cmd;
    logic [IDX_W-1:0]   idx;
    logic [LEN_W-1:0]   len;
    logic [DATA_W-1:0]  value;
    logic [DATA_W-1:0]  key;
  } cell_ctl_t;

endpackage

// ===== src/olst_cell.sv =====
// ----------------------------------------------------------------------------
// olst_cell
// One list slot: holds an element, shifts it toward either neighbor on
// insert, delete or read-out rotation, and compares it against the key.
// ----------------------------------------------------------------------------
module olst_cell (
  input  logic                          clk_i,
  input  olst_pkg::cell_ctl_t           ctl_i,
  input  logic [olst_pkg::IDX_W-1:0]    pos_i,
  input  logic [olst_pkg::DATA_W-1:0]   left_i,
  input  logic [olst_pkg::DATA_W-1:0]   right_i,
  input  logic [olst_pkg::DATA_W-1:0]   head_i,
  output logic [olst_pkg::DATA_W-1:0]   data_o,
  output logic                          match_o
);
  import olst_pkg::*;

  logic [DATA_W-1:0] data_q, data_d;
  logic              in_list;
  logic              is_tail;

  assign in_list = (LEN_W+1)'(pos_i) < (LEN_W+1)'(ctl_i.len);
  assign is_tail = ((LEN_W+1)'(pos_i) + (LEN_W+1)'(1)) == (LEN_W+1)'(ctl_i.len);
  assign match_o = in_list && (data_q == ctl_i.key);
  assign data_o  = data_q;

  always_comb begin
    data_d = data_q;
    case (ctl_i.cmd)
      CMD_INS: begin
        if (pos_i > ctl_i.idx) begin
          data_d = left_i;
        end else if (pos_i == ctl_i.idx) begin
          data_d = ctl_i.value;
        end
      end
      CMD_DEL: begin
        if (pos_i >= ctl_i.idx) begin
          data_d = right_i;
        end
      end
      CMD_ROT: begin
        data_d = is_tail ? head_i : right_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// ===== src/ordered_list_store.sv =====
// ----------------------------------------------------------------------------
// ordered_list_store
// Bounded ordered list of signed 32-bit values kept in a chain of shift
// cells; inserts, deletes, searches and in-order read-out.
//
//   channel   dir  tdata fields (low to high)               side fields
//   s_axis    in   value[31:0] position[36:32] key[68:37]  tuser = op
//   m_axis    out  status found_position element length    tlast = last
//
// Insert, delete and search each yield one result. An input transaction is
// taken every cycle while the output register is free or being drained; a
// stalled output holds its register and blocks further input. Read all
// yields length results (at least one), one per cycle unless the output
// stalls, paced by a one-element cell chain rotation per result; input is
// held off meanwhile. Reset clears length, state, count and valid, not cells.
// ----------------------------------------------------------------------------
module ordered_list_store (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // value, position, key, zero pad
  input  logic [olst_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // op
  input  logic [olst_pkg::OP_W-1:0]         s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // status, found_position, element, length, zero pad
  output logic [olst_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output logic                              m_axis_tlast_o
);
  import olst_pkg::*;

  typedef enum logic [1:0] {
    S_RUN  = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [IDX_W-1:0]   rd_cnt_q, rd_cnt_d;

  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic [POS_W-1:0]   out_fpos_q, out_fpos_d;
  logic [DATA_W-1:0]  out_elem_q, out_elem_d;
  logic [LEN_W-1:0]   out_len_q, out_len_d;
  logic               out_last_q, out_last_d;

  op_e                op;
  logic [DATA_W-1:0]  in_value;
  logic [POS_W-1:0]   in_pos;
  logic [DATA_W-1:0]  in_key;
  logic [LEN_W:0]     pos_ext;
  logic [LEN_W:0]     len_ext;
  logic               slot_free;
  logic               accept;
  logic               rd_step;
  logic               rd_last;

  cell_ctl_t          ctl;
  logic [DATA_W-1:0]  cell_data [DEPTH];
  logic [DEPTH-1:0]   cell_match;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;

  assign op       = op_e'(s_axis_tuser_i);
  assign in_value = s_axis_tdata_i[DATA_W-1:0];
  assign in_pos   = s_axis_tdata_i[DATA_W +: POS_W];
  assign in_key   = s_axis_tdata_i[DATA_W+POS_W +: DATA_W];
  assign pos_ext  = (LEN_W+1)'(in_pos);
  assign len_ext  = (LEN_W+1)'(len_q);

  assign slot_free       = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_RUN) && slot_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign rd_step         = (state_q == S_READ) && slot_free;
  assign rd_last = ((LEN_W+1)'(rd_cnt_q) + (LEN_W+1)'(1)) == len_ext;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = ctl.value;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right = cell_data[g];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    olst_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .pos_i   (IDX_W'(g)),
      .left_i  (left),
      .right_i (right),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[g]),
      .match_o (cell_match[g])
    );
  end

  always_comb begin
    ctl.cmd      = CMD_HOLD;
    ctl.idx      = '0;
    ctl.len      = len_q;
    ctl.value    = in_value;
    ctl.key      = in_key;
    state_d      = state_q;
    len_d        = len_q;
    rd_cnt_d     = rd_cnt_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_fpos_d   = out_fpos_q;
    out_elem_d   = out_elem_q;
    out_len_d    = out_len_q;
    out_last_d   = out_last_q;

    if (accept) begin
      out_valid_d  = 1'b1;
      out_status_d = ST_OK;
      out_fpos_d   = '0;
      out_elem_d   = '0;
      out_last_d   = 1'b1;
      case (op)
        OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
          if (len_q == LEN_W'(DEPTH)) begin
            out_status_d = ST_FULL;
          end else if (op == OP_INS_AT &&
                       (in_pos == '0 || pos_ext > len_ext + (LEN_W+1)'(1))) begin
            out_status_d = ST_BADPOS;
          end else begin
            ctl.cmd = CMD_INS;
            if (op == OP_INS_BACK) begin
              ctl.idx = len_q[IDX_W-1:0];
            end else if (op == OP_INS_AT) begin
              ctl.idx = IDX_W'(in_pos - POS_W'(1));
            end
            len_d = len_q + LEN_W'(1);
          end
        end
        OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
          if (len_q == '0) begin
            out_status_d = ST_EMPTY;
          end else if (op == OP_DEL_AT && (in_pos == '0 || pos_ext > len_ext)) begin
            out_status_d = ST_BADPOS;
          end else begin
            ctl.cmd = CMD_DEL;
            if (op == OP_DEL_BACK) begin
              ctl.idx = IDX_W'(len_q - LEN_W'(1));
            end else if (op == OP_DEL_AT) begin
              ctl.idx = IDX_W'(in_pos - POS_W'(1));
            end
            len_d = len_q - LEN_W'(1);
          end
        end
        OP_SEARCH: begin
          if (len_q == '0) begin
            out_status_d = ST_EMPTY;
          end else if (hit) begin
            out_fpos_d = POS_W'(hit_idx) + POS_W'(1);
          end else begin
            out_status_d = ST_NOKEY;
          end
        end
        OP_READ_ALL: begin
          if (len_q == '0) begin
            out_status_d = ST_EMPTY;
          end else begin
            out_valid_d = out_valid_q && !m_axis_tready_i;
            state_d     = S_READ;
            rd_cnt_d    = '0;
          end
        end
        default: out_status_d = ST_OK;
      endcase
      out_len_d = len_d;
    end else if (rd_step) begin
      ctl.cmd      = CMD_ROT;
      out_valid_d  = 1'b1;
      out_status_d = ST_OK;
      out_fpos_d   = '0;
      out_elem_d   = cell_data[0];
      out_len_d    = len_q;
      out_last_d   = rd_last;
      rd_cnt_d     = rd_cnt_q + IDX_W'(1);
      if (rd_last) begin
        state_d = S_RUN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      len_q       <= '0;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      rd_cnt_q    <= rd_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_fpos_q   <= out_fpos_d;
    out_elem_q   <= out_elem_d;
    out_len_q    <= out_len_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({out_len_q, out_elem_q, out_fpos_q, out_status_q});

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(DEPTH))
    else $error("list length beyond depth");

  a_read_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !s_axis_tready_o)
    else $error("input taken during read-out");

  a_error_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_status_q != ST_OK) |-> m_axis_tlast_o)
    else $error("error result not marked last");

  a_len_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> (len_q == $past(len_q)))
    else $error("length changed without a transaction");

endmodule
